[design/aba_pkg.sv]
`default_nettype none

package aba_pkg;

  // Fixed geometry of the bitmap and the request fields
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int ADDR_W    = 8;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_RESERVE = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    cmd_e              command;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] granted_address;
    logic              in_use;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load_req;
    logic scan_step;
    logic commit;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_alloc;
    logic word_free;
    logic scan_last;
    logic slot_free;
  } dp_sts_t;

endpackage

`default_nettype wire

[design/aba_ctrl.sv]
`default_nettype none

module aba_ctrl
  import aba_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dp_sts_t  sts_i,
  output ctl_cmd_t      cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence one transaction: take it, scan if allocating, then commit
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = sts_i.req_alloc ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.word_free || sts_i.scan_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        // Hold until the output register can take the result
        if (sts_i.slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/aba_datapath.sv]
`default_nettype none

module aba_datapath
  import aba_pkg::*;
#(
  parameter int MAP_WORDS = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire req_t     in_req_i,
  input  wire ctl_cmd_t cmd_i,
  output dp_sts_t       sts_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output rsp_t          out_rsp_o
);

  localparam int WIDX     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int MAP_BITS = MAP_WORDS * WORD_BITS;

  // Position of the lowest clear bit of a word
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] word);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!word[b]) begin
        pos = BIT_W'(b);
      end
    end
    return pos;
  endfunction

  logic [WORD_BITS-1:0] map_q [MAP_WORDS];
  req_t                 req_q;
  logic [WIDX-1:0]      scan_idx_q;
  logic                 found_q;
  logic [WIDX-1:0]      hit_word_q;
  logic [BIT_W-1:0]     hit_bit_q;
  rsp_t                 out_q;
  logic                 out_valid_q;

  logic                 in_range;
  logic [WIDX-1:0]      addr_word;
  logic [BIT_W-1:0]     addr_bit;
  logic [WIDX-1:0]      rd_idx;
  logic [WORD_BITS-1:0] rd_word;
  logic                 word_free;
  logic                 scan_last;
  logic [BIT_W-1:0]     free_bit;
  rsp_t                 rsp_d;
  logic                 wr_en;
  logic [WIDX-1:0]      wr_idx;
  logic [BIT_W-1:0]     wr_bit;
  logic                 wr_val;

  // Decode the requested address
  assign in_range  = {1'b0, req_q.address} < 9'(MAP_BITS);
  assign addr_word = in_range ? req_q.address[BIT_W +: WIDX] : '0;
  assign addr_bit  = req_q.address[BIT_W-1:0];

  // Read one bitmap word: the scanned one or the addressed one
  assign rd_idx    = cmd_i.scan_step ? scan_idx_q : addr_word;
  assign rd_word   = map_q[rd_idx];
  assign word_free = ~&rd_word;
  assign free_bit  = lowest_zero(rd_word);
  assign scan_last = scan_idx_q == WIDX'(MAP_WORDS - 1);

  // Capture the request, and the word and bit of the first free bit found by the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_req_i;
    end
    if (cmd_i.scan_step && word_free && !found_q) begin
      hit_word_q <= scan_idx_q;
      hit_bit_q  <= free_bit;
    end
  end

  // Advance the scan one word per cycle, stop at the first free bit or at the last word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      found_q    <= 1'b0;
    end else if (cmd_i.load_req) begin
      scan_idx_q <= '0;
      found_q    <= 1'b0;
    end else if (cmd_i.scan_step && !found_q) begin
      if (word_free) begin
        found_q <= 1'b1;
      end else if (!scan_last) begin
        scan_idx_q <= scan_idx_q + WIDX'(1);
      end
    end
  end

  // Form the result and the bitmap update
  always_comb begin
    rsp_d                 = '0;
    rsp_d.status          = STAT_OK;
    wr_en                 = 1'b0;
    wr_idx                = addr_word;
    wr_bit                = addr_bit;
    wr_val                = 1'b0;
    case (req_q.command)
      CMD_ALLOC: begin
        if (found_q) begin
          rsp_d.granted_address = ADDR_W'({hit_word_q, hit_bit_q});
          wr_en                 = 1'b1;
          wr_idx                = hit_word_q;
          wr_bit                = hit_bit_q;
          wr_val                = 1'b1;
        end else begin
          rsp_d.status = STAT_FULL;
        end
      end
      CMD_RELEASE: begin
        if (!in_range) begin
          rsp_d.status = STAT_RANGE;
        end else begin
          wr_en = 1'b1;
        end
      end
      CMD_RESERVE: begin
        if (!in_range) begin
          rsp_d.status = STAT_RANGE;
        end else begin
          wr_en  = 1'b1;
          wr_val = 1'b1;
        end
      end
      CMD_QUERY: begin
        if (!in_range) begin
          rsp_d.status = STAT_RANGE;
        end else begin
          rsp_d.in_use = rd_word[addr_bit];
        end
      end
      default: begin
        rsp_d.status = STAT_OK;
      end
    endcase
  end

  // Bitmap: all free after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < MAP_WORDS; w++) begin
        map_q[w] <= '0;
      end
    end else if (cmd_i.commit && wr_en) begin
      map_q[wr_idx][wr_bit] <= wr_val;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign sts_o.req_alloc = in_req_i.command == CMD_ALLOC;
  assign sts_o.word_free = word_free;
  assign sts_o.scan_last = scan_last;
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || out_ready_i))
    else $error("result committed over a waiting transaction");

  a_alloc_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && req_q.command == CMD_ALLOC && found_q)
    |=> map_q[$past(hit_word_q)][$past(hit_bit_q)])
    else $error("allocated address not marked used");

  a_grant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ({1'b0, out_q.granted_address} < 9'(MAP_BITS)))
    else $error("granted address beyond the map");

  a_query_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.in_use)
    |-> (out_q.status == STAT_OK && out_q.granted_address == '0))
    else $error("in_use reported on a failed or non-query transaction");

endmodule

`default_nettype wire

[design/address_bitmap_allocator.sv]
// Address bitmap allocator: keeps one used bit per address for MAP_WORDS*32
// addresses, all free after reset. Allocate returns the lowest free address
// and marks it used (status 2 when none is free); release, reserve and query
// act on the given address (status 1 when it is at or beyond MAP_WORDS*32).
// One transaction is handled at a time: release, reserve and query skip
// the scan, while allocate first reads 1 to MAP_WORDS 32-bit bitmap words,
// one word per cycle through a single read port, up to the first word with
// a free bit. A new request is taken while a previous result still waits in
// the output register.
`default_nettype none

module address_bitmap_allocator
  import aba_pkg::*;
#(
  parameter int MAP_WORDS = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_rsp_o
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  aba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  aba_datapath #(
    .MAP_WORDS (MAP_WORDS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

[tb/address_bitmap_allocator_test.sv]
`default_nettype none

module address_bitmap_allocator_test
  import aba_pkg::*;
;

  localparam int MAP_WORDS   = 4;
  localparam int ADDR_LIMIT  = MAP_WORDS * WORD_BITS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1200;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_rsp_o;

  // Long window with no idling on either side
  logic quiet;
  int   cycle_count;

  // Own copy of the used bitmap and the queue of awaited responses
  class alloc_scoreboard;
    logic [WORD_BITS-1:0] used_words [MAP_WORDS];
    rsp_t                 pending_rsp [$];
    int                   error_count;

    function new();
      for (int w = 0; w < MAP_WORDS; w++) used_words[w] = '0;
      error_count = 0;
    endfunction

    task report(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
    endtask

    // Apply one accepted request to the bitmap and queue its response
    function void note_request(input req_t r);
      rsp_t exp_rsp;
      int   word;
      int   bit_idx;
      bit   found;
      exp_rsp.status          = STAT_OK;
      exp_rsp.granted_address = '0;
      exp_rsp.in_use          = 1'b0;
      found                   = 1'b0;
      if (r.command == CMD_ALLOC) begin
        for (int w = 0; w < MAP_WORDS && !found; w++) begin
          for (int b = 0; b < WORD_BITS && !found; b++) begin
            if (!used_words[w][b]) begin
              used_words[w][b]        = 1'b1;
              exp_rsp.granted_address = ADDR_W'(w * WORD_BITS + b);
              found                   = 1'b1;
            end
          end
        end
        if (!found) exp_rsp.status = STAT_FULL;
      end else if (int'(r.address) >= ADDR_LIMIT) begin
        exp_rsp.status = STAT_RANGE;
      end else begin
        word    = int'(r.address) / WORD_BITS;
        bit_idx = int'(r.address) % WORD_BITS;
        case (r.command)
          CMD_RELEASE: used_words[word][bit_idx] = 1'b0;
          CMD_RESERVE: used_words[word][bit_idx] = 1'b1;
          default:     exp_rsp.in_use = used_words[word][bit_idx];
        endcase
      end
      pending_rsp.push_back(exp_rsp);
    endfunction

    // Compare one delivered response against the oldest awaited one
    task check_response(input rsp_t got);
      rsp_t exp_rsp;
      if (pending_rsp.size() == 0) begin
        report("response with no request pending");
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (got.status !== exp_rsp.status)
          report($sformatf("status %0d, expected %0d", got.status, exp_rsp.status));
        if (got.granted_address !== exp_rsp.granted_address)
          report($sformatf("granted_address %0d, expected %0d",
                           got.granted_address, exp_rsp.granted_address));
        if (got.in_use !== exp_rsp.in_use)
          report($sformatf("in_use %0b, expected %0b", got.in_use, exp_rsp.in_use));
      end
    endtask
  endclass

  alloc_scoreboard board;

  address_bitmap_allocator #(
    .MAP_WORDS(MAP_WORDS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Give up after a generous number of cycles
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Take responses, stalling at random outside the quiet window
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_ready_i) board.check_response(out_rsp_o);
    out_ready_i <= quiet || ($urandom_range(99) >= 9);
  end

  // Present one request, idling first at random, and hold it until taken
  task send_request(input cmd_e cmd, input logic [ADDR_W-1:0] addr);
    req_t r;
    r.command = cmd;
    r.address = addr;
    while (!quiet && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    board.note_request(r);
  endtask

  initial begin
    int   phase_left;
    bit   alloc_bias;
    int   pick;
    cmd_e cmd;
    logic [ADDR_W-1:0] addr;

    board       = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    quiet       = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: first grants, repeated release and reserve, top of range,
    // out-of-range addresses, word boundary, refill of a released slot
    send_request(CMD_ALLOC,   8'hFF);
    send_request(CMD_ALLOC,   8'h00);
    send_request(CMD_QUERY,   8'd0);
    send_request(CMD_RELEASE, 8'd0);
    send_request(CMD_RELEASE, 8'd0);
    send_request(CMD_QUERY,   8'd0);
    send_request(CMD_ALLOC,   8'h7F);
    send_request(CMD_RESERVE, 8'd127);
    send_request(CMD_RESERVE, 8'd127);
    send_request(CMD_QUERY,   8'd127);
    send_request(CMD_QUERY,   8'd128);
    send_request(CMD_RELEASE, 8'd255);
    send_request(CMD_RESERVE, 8'd200);
    send_request(CMD_QUERY,   8'd126);
    send_request(CMD_RELEASE, 8'd127);
    send_request(CMD_RESERVE, 8'd32);
    send_request(CMD_QUERY,   8'd31);
    send_request(CMD_QUERY,   8'd32);
    send_request(CMD_ALLOC,   8'hAA);
    send_request(CMD_RELEASE, 8'd1);
    send_request(CMD_ALLOC,   8'h55);
    send_request(CMD_QUERY,   8'h55);

    // Random: phases that lean towards allocate (filling the map up to
    // full) alternate with phases that lean towards release
    alloc_bias = 1'b1;
    phase_left = $urandom_range(180, 240);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 500 && n < 700);
      if (phase_left == 0) begin
        alloc_bias = ~alloc_bias;
        phase_left = $urandom_range(120, 220);
      end
      phase_left--;
      pick = $urandom_range(99);
      if (alloc_bias)
        cmd = (pick < 70) ? CMD_ALLOC : (pick < 80) ? CMD_RELEASE :
              (pick < 90) ? CMD_RESERVE : CMD_QUERY;
      else
        cmd = (pick < 15) ? CMD_ALLOC : (pick < 70) ? CMD_RELEASE :
              (pick < 80) ? CMD_RESERVE : CMD_QUERY;
      // Mostly in-range addresses, some anywhere in the field
      if ($urandom_range(99) < 12)
        addr = ADDR_W'($urandom_range(255));
      else
        addr = ADDR_W'($urandom_range(ADDR_LIMIT - 1));
      send_request(cmd, addr);
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    // Drain outstanding responses, then allow for the scan latency
    while (board.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (4 * (2 + MAP_WORDS)) @(posedge clk_i);

    if (board.error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
design/aba_pkg.sv
design/aba_ctrl.sv
design/aba_datapath.sv
design/address_bitmap_allocator.sv
tb/address_bitmap_allocator_test.sv
